// ===== rtl/sas_pkg.sv =====
`timescale 1ns / 1ps
package sas_pkg;

   localparam int MAX_SUBSTEPS = 64;
   localparam int CNT_W        = 7;
   localparam int ADDR_W       = 5;
   localparam int DIV_W        = 56;
   localparam int DIV_DIGITS   = DIV_W / 8;

   localparam logic [2:0] METH_NONE  = 3'd0;
   localparam logic [2:0] METH_EULER = 3'd1;
   localparam logic [2:0] METH_TRAP  = 3'd2;
   localparam logic [2:0] METH_AB2   = 3'd3;
   localparam logic [2:0] METH_AB3   = 3'd4;

   localparam logic [2:0] REG_OMEGA_SQ  = 3'd0;
   localparam logic [2:0] REG_TZO       = 3'd1;
   localparam logic [2:0] REG_MIN_POS   = 3'd2;
   localparam logic [2:0] REG_MAX_POS   = 3'd3;
   localparam logic [2:0] REG_MAX_RATE  = 3'd4;
   localparam logic [2:0] REG_DT        = 3'd5;
   localparam logic [2:0] REG_COUNT     = 3'd6;
   localparam logic [2:0] REG_MODE      = 3'd7;

   localparam logic signed [50:0] D48_MAX = 51'sd140737488355327;
   localparam logic signed [50:0] D48_MIN = -51'sd140737488355328;
   localparam logic signed [55:0] S32_MAX = 56'sd2147483647;
   localparam logic signed [55:0] S32_MIN = -56'sd2147483648;
   localparam logic [55:0] DIV_OFFSET = 56'd3 << 53;
   localparam logic [55:0] DIV_BIAS   = 56'd1 << 53;

   typedef struct packed {
      logic [31:0] omega_sq;
      logic [31:0] two_zeta_omega;
      logic signed [31:0] min_position;
      logic signed [31:0] max_position;
      logic [30:0] max_rate;
      logic [23:0] substep_dt;
      logic [6:0]  substep_count;
      logic [3:0]  mode;
   } cfg_type;

endpackage

// ===== rtl/sas_chan_if.sv =====
`timescale 1ns / 1ps
interface sas_req_if import sas_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [31:0] demand;
   logic failure;
   modport source (output valid, output demand, output failure, input ready);
   modport sink (input valid, input demand, input failure, output ready);
endinterface

interface sas_rsp_if import sas_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [31:0] deflection;
   logic signed [31:0] rate;
   modport source (output valid, output deflection, output rate, input ready);
   modport sink (input valid, input deflection, input rate, output ready);
endinterface

// ===== rtl/sas_mul.sv =====
`timescale 1ns / 1ps
module sas_mul import sas_pkg::*; (
   input  logic clock,
   input  logic signed [33:0] a,
   input  logic signed [33:0] b,
   output logic signed [67:0] p_ff
);
   always_ff @(posedge clock) begin
      p_ff <= a * b;
   end
endmodule

// ===== rtl/sas_div.sv =====
`timescale 1ns / 1ps
module sas_div import sas_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [DIV_W-1:0] x,
   output logic done_ff,
   output logic [DIV_W-1:0] q_ff
);
   logic [DIV_W-1:0] x_ff;
   logic [1:0] rem_ff;
   logic [2:0] cnt_ff;
   logic active_ff;
   logic [9:0] cur;
   logic [20:0] recip;
   logic [7:0] qd;
   logic [9:0] back;
   logic [1:0] rem_in;

   // divide by three, one byte per cycle
   always_comb begin
      cur    = {rem_ff, x_ff[DIV_W-1 -: 8]};
      recip  = 21'(cur) * 21'd683;
      qd     = recip[18:11];
      back   = 10'(qd) * 10'd3;
      rem_in = 2'(cur - back);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            active_ff <= 1'b1;
            cnt_ff    <= '0;
            rem_ff    <= '0;
            x_ff      <= x;
         end else if (active_ff) begin
            x_ff   <= {x_ff[DIV_W-9:0], 8'd0};
            q_ff   <= {q_ff[DIV_W-9:0], qd};
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == 3'(DIV_DIGITS - 1)) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end
         end
      end
   end
endmodule

// ===== rtl/sas_csr.sv =====
`timescale 1ns / 1ps
module sas_csr import sas_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready,
   output cfg_type cfg_ff
);
   logic [2:0] idx;
   logic wr;

   assign idx = csr_paddr[ADDR_W-1:2];
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.omega_sq       <= 32'd40960000;
         cfg_ff.two_zeta_omega <= 32'd2293760;
         cfg_ff.min_position   <= -32'sd8782405;
         cfg_ff.max_position   <= 32'sd4976696;
         cfg_ff.max_rate       <= 31'd11709873;
         cfg_ff.substep_dt     <= 24'd167772;
         cfg_ff.substep_count  <= 7'd1;
         cfg_ff.mode           <= 4'd9;
      end else if (wr) begin
         unique case (idx)
            REG_OMEGA_SQ: cfg_ff.omega_sq <= csr_pwdata;
            REG_TZO:      cfg_ff.two_zeta_omega <= csr_pwdata;
            REG_MIN_POS:  cfg_ff.min_position <= csr_pwdata;
            REG_MAX_POS:  cfg_ff.max_position <= csr_pwdata;
            REG_MAX_RATE: cfg_ff.max_rate <= csr_pwdata[30:0];
            REG_DT:       cfg_ff.substep_dt <= csr_pwdata[23:0];
            REG_COUNT:    cfg_ff.substep_count <= csr_pwdata[6:0];
            REG_MODE:     cfg_ff.mode <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_OMEGA_SQ: csr_prdata = cfg_ff.omega_sq;
         REG_TZO:      csr_prdata = cfg_ff.two_zeta_omega;
         REG_MIN_POS:  csr_prdata = cfg_ff.min_position;
         REG_MAX_POS:  csr_prdata = cfg_ff.max_position;
         REG_MAX_RATE: csr_prdata = {1'b0, cfg_ff.max_rate};
         REG_DT:       csr_prdata = {8'd0, cfg_ff.substep_dt};
         REG_COUNT:    csr_prdata = {25'd0, cfg_ff.substep_count};
         REG_MODE:     csr_prdata = {28'd0, cfg_ff.mode};
         default:      csr_prdata = '0;
      endcase
   end
endmodule

// ===== rtl/second_order_actuator_sim_unit.sv =====
`timescale 1ns / 1ps
// channel   dir   payload                     handshake
// req_bus   in    demand[31:0], failure       valid/ready
// rsp_bus   out   deflection[31:0], rate[31:0] valid/ready
// csr_*     in    apb write/read, 32 bit      psel/penable, pready tied high
// each substep: the rate derivative (d1a, d1b, d1c), then per increment either setup alone
// with no integrator, or setup and mhi, mlo, msum through the one 34x34 multiplier, plus for ab3
// the byte-serial divide by three; then a state update; up to 64 substeps
// a frame is n substeps followed by fin and out; req ready only while idle
// the result waits in place until taken; synchronous reset clears fsm, pos, rate, held, history
module second_order_actuator_sim_unit import sas_pkg::*; (
   input  logic clock,
   input  logic reset,
   sas_req_if.sink req_bus,
   sas_rsp_if.source rsp_bus,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   typedef enum logic [3:0] {
      S_IDLE, S_D1A, S_D1B, S_D1C, S_CSET, S_MHI, S_MLO, S_MSUM, S_DIVW, S_UPD, S_FIN, S_OUT
   } state_type;

   cfg_type cfg;
   state_type state_ff;
   logic signed [31:0] pos_ff, vel_ff, held_ff, dem_ff;
   logic fail_ff;
   logic signed [47:0] h1_ff [2];
   logic signed [47:0] h2_ff [2];
   logic signed [47:0] d1_ff;
   logic signed [49:0] t1_ff;
   logic signed [53:0] c_ff;
   logic signed [54:0] mhi_ff;
   logic signed [54:0] inc_ff [2];
   logic j_ff;
   logic [CNT_W-1:0] cnt_ff;

   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] prod;
   logic div_start, div_done;
   logic [DIV_W-1:0] div_x, div_q;

   logic [2:0] method;
   logic sat;
   logic [CNT_W-1:0] n;
   logic signed [31:0] dem_in;
   logic signed [50:0] diff;
   logic signed [47:0] d1_in;
   logic signed [53:0] d_x, l_x, l2_x, c_in;
   logic signed [54:0] m_sum;
   logic signed [55:0] p_sum, v_sum;
   logic signed [31:0] p_cl, v_cl, pos_in, vel_in;
   logic signed [32:0] v_w, rate_lim;

   sas_csr u_csr (
      .clock(clock), .reset(reset), .csr_psel(csr_psel), .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready), .cfg_ff(cfg)
   );

   sas_mul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .p_ff(prod));

   sas_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .x(div_x),
      .done_ff(div_done), .q_ff(div_q)
   );

   assign method = cfg.mode[2:0];
   assign sat = cfg.mode[3];
   assign n = (cfg.substep_count > CNT_W'(MAX_SUBSTEPS)) ? CNT_W'(MAX_SUBSTEPS)
                                                         : cfg.substep_count;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign rsp_bus.valid = (state_ff == S_OUT);
   assign rsp_bus.deflection = held_ff;
   assign rsp_bus.rate = vel_ff;

   always_comb begin
      dem_in = req_bus.demand;
      if (sat) begin
         if (req_bus.demand > cfg.max_position) dem_in = cfg.max_position;
         else if (req_bus.demand < cfg.min_position) dem_in = cfg.min_position;
      end
   end

   always_comb begin
      unique case (state_ff)
         S_D1A: begin
            mul_a = 34'(33'(dem_ff) - 33'(pos_ff));
            mul_b = {2'b00, cfg.omega_sq};
         end
         S_D1B: begin
            mul_a = 34'(vel_ff);
            mul_b = {2'b00, cfg.two_zeta_omega};
         end
         S_MHI: begin
            mul_a = 34'($signed(c_ff[53:24]));
            mul_b = {10'd0, cfg.substep_dt};
         end
         S_MLO: begin
            mul_a = {10'd0, c_ff[23:0]};
            mul_b = {10'd0, cfg.substep_dt};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      diff = 51'(t1_ff) - 51'($signed(prod[65:16]));
      if (diff > D48_MAX) d1_in = D48_MAX[47:0];
      else if (diff < D48_MIN) d1_in = D48_MIN[47:0];
      else d1_in = diff[47:0];

      d_x  = j_ff ? 54'(d1_ff) : 54'(vel_ff);
      l_x  = 54'(h1_ff[j_ff]);
      l2_x = 54'(h2_ff[j_ff]);
      unique case (method)
         METH_TRAP: c_in = d_x + l_x;
         METH_AB2:  c_in = 54'sd3 * d_x - l_x;
         METH_AB3:  c_in = 54'sd23 * d_x - 54'sd16 * l_x + 54'sd5 * l2_x;
         default:   c_in = d_x;
      endcase

      m_sum = mhi_ff + 55'($signed({31'd0, prod[47:24]}));
      div_start = (state_ff == S_MSUM) && (method == METH_AB3);
      div_x = 56'(m_sum >>> 2) + DIV_OFFSET;

      p_sum = 56'(pos_ff) + 56'(inc_ff[0]);
      v_sum = 56'(vel_ff) + 56'(inc_ff[1]);
      p_cl = (p_sum > S32_MAX) ? S32_MAX[31:0] : (p_sum < S32_MIN) ? S32_MIN[31:0] : p_sum[31:0];
      v_cl = (v_sum > S32_MAX) ? S32_MAX[31:0] : (v_sum < S32_MIN) ? S32_MIN[31:0] : v_sum[31:0];
      rate_lim = $signed({2'b00, cfg.max_rate});
      v_w = 33'(v_cl);
      pos_in = p_cl;
      vel_in = v_cl;
      if (sat) begin
         if (v_w > rate_lim) vel_in = 32'(rate_lim);
         else if (v_w < -rate_lim) vel_in = 32'(-rate_lim);
         if (p_cl > cfg.max_position) begin
            pos_in = cfg.max_position;
            vel_in = '0;
         end else if (p_cl < cfg.min_position) begin
            pos_in = cfg.min_position;
            vel_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pos_ff   <= '0;
         vel_ff   <= '0;
         held_ff  <= '0;
         h1_ff[0] <= '0;
         h1_ff[1] <= '0;
         h2_ff[0] <= '0;
         h2_ff[1] <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_bus.valid) begin
                  dem_ff  <= dem_in;
                  fail_ff <= req_bus.failure;
                  cnt_ff  <= '0;
                  state_ff <= (n == '0) ? S_FIN : S_D1A;
               end
            end
            S_D1A: state_ff <= S_D1B;
            S_D1B: begin
               t1_ff <= prod[65:16];
               state_ff <= S_D1C;
            end
            S_D1C: begin
               d1_ff <= d1_in;
               j_ff  <= 1'b0;
               state_ff <= S_CSET;
            end
            S_CSET: begin
               c_ff <= c_in;
               if (method == METH_EULER || method == METH_TRAP ||
                   method == METH_AB2 || method == METH_AB3) begin
                  state_ff <= S_MHI;
               end else begin
                  inc_ff[j_ff] <= '0;
                  j_ff <= 1'b1;
                  state_ff <= j_ff ? S_UPD : S_CSET;
               end
            end
            S_MHI: state_ff <= S_MLO;
            S_MLO: begin
               mhi_ff <= prod[54:0];
               state_ff <= S_MSUM;
            end
            S_MSUM: begin
               if (method == METH_AB3) begin
                  state_ff <= S_DIVW;
               end else begin
                  inc_ff[j_ff] <= (method == METH_EULER) ? m_sum : (m_sum >>> 1);
                  j_ff <= 1'b1;
                  state_ff <= j_ff ? S_UPD : S_CSET;
               end
            end
            S_DIVW: begin
               if (div_done) begin
                  inc_ff[j_ff] <= 55'(div_q - DIV_BIAS);
                  j_ff <= 1'b1;
                  state_ff <= j_ff ? S_UPD : S_CSET;
               end
            end
            S_UPD: begin
               pos_ff   <= pos_in;
               vel_ff   <= vel_in;
               h2_ff[0] <= h1_ff[0];
               h2_ff[1] <= h1_ff[1];
               h1_ff[0] <= 48'(vel_ff);
               h1_ff[1] <= d1_ff;
               cnt_ff   <= cnt_ff + 1'b1;
               state_ff <= (cnt_ff + 1'b1 == n) ? S_FIN : S_D1A;
            end
            S_FIN: begin
               if (!fail_ff) held_ff <= pos_ff;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (rsp_bus.ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
